// ----- design/bwss_pkg.sv -----
// bwss_pkg: shared types and fixed widths for the bounded window sum search
// holds the sequencer state type and the score / kept-run structs
// no dependencies
package bwss_pkg;

  localparam int VALUE_W  = 16;
  localparam int IDX_W    = 20;
  localparam int BUDGET_W = 32;
  localparam int SUM_W    = 33;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_CHECK,
    ST_FINAL,
    ST_EMIT
  } state_t;

  // one scoring request: candidate run sum and its 1-based bounds
  typedef struct packed {
    logic                en;
    logic [SUM_W-1:0]    sum;
    logic [IDX_W-1:0]    first_idx;
    logic [IDX_W-1:0]    last_idx;
  } score_req_t;

  // best run kept so far
  typedef struct packed {
    logic [BUDGET_W-1:0] sum;
    logic [IDX_W-1:0]    first_idx;
    logic [IDX_W-1:0]    last_idx;
  } kept_t;

endpackage

// ----- design/bwss_if.sv -----
// bwss_in_if / bwss_out_if: valid-ready channels of the window sum search
// payload widths come from bwss_pkg
interface bwss_in_if;
  logic                         valid;
  logic                         ready;
  logic [bwss_pkg::VALUE_W-1:0] value;
  logic                         last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface bwss_out_if;
  logic                          valid;
  logic                          ready;
  logic [bwss_pkg::IDX_W-1:0]    best_start;
  logic [bwss_pkg::IDX_W-1:0]    best_end;
  logic [bwss_pkg::BUDGET_W-1:0] best_sum;
  logic                          window_overflow;

  modport source (output valid, output best_start, output best_end, output best_sum,
                  output window_overflow, input ready);
  modport sink   (input valid, input best_start, input best_end, input best_sum,
                  input window_overflow, output ready);
endinterface

// ----- design/bwss_keeper.sv -----
// bwss_keeper: holds the best run found so far and scores candidate windows
// a candidate wins only if strictly larger than the kept sum and within budget
// depends on bwss_pkg
module bwss_keeper (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bwss_pkg::BUDGET_W-1:0] budget,
  input  bwss_pkg::score_req_t          req,
  input  logic                          clear,
  output bwss_pkg::kept_t               kept
);

  bwss_pkg::kept_t kept_r;
  logic            upd;

  // strict compare keeps the earliest run on ties
  assign upd = req.en &&
               (req.sum > {1'b0, kept_r.sum}) &&
               (req.sum <= {1'b0, budget});

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      kept_r <= '0;
    end else if (upd) begin
      kept_r.sum       <= req.sum[bwss_pkg::BUDGET_W-1:0];
      kept_r.first_idx <= req.first_idx;
      kept_r.last_idx  <= req.last_idx;
    end
  end

  assign kept = kept_r;

  // kept sum only grows within a sequence
  a_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(clear) |-> kept_r.sum >= $past(kept_r.sum))
    else $error("kept sum decreased without clear");

  // kept run changes only through a request or a clear
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (kept_r != $past(kept_r)) |-> ($past(req.en) || $past(clear)))
    else $error("kept run changed without cause");

  // an empty kept sum means no run was ever taken
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    (kept_r.sum == '0) |-> (kept_r.first_idx == '0 && kept_r.last_idx == '0))
    else $error("kept bounds set with zero sum");

endmodule

// ----- design/bounded_window_sum_search_top.sv -----
// bounded_window_sum_search_top: two-pointer search for the largest run sum within budget
// window values live in a ring memory with a registered read of the oldest entry
// depends on bwss_pkg, bwss_in_if, bwss_out_if, bwss_keeper
//
//  channel   | direction | transaction / payload
//  ----------+-----------+----------------------------------------------
//  in_chan   | sink      | value[15:0], last
//  out_chan  | source    | best_start[19:0], best_end[19:0], best_sum[31:0],
//            |           | window_overflow (one per sequence, on last)
//  cfg_*     | write     | cfg_we, cfg_wdata[31:0] = budget
//
// An item is pushed on accept, then checked, dropping the oldest element (one memory read per
// drop) while over budget; a full store drops its oldest before the push, and an item marked
// last adds the final and emit steps. An element past the item limit is not stored.
// Reset is synchronous; the ring memory is not cleared, only written entries are read.
// The result waits in an output register; a stalled result holds the block before
// it starts the next sequence.
module bounded_window_sum_search_top #(
  parameter int WINDOW_DEPTH = 1024,
  parameter int MAX_ITEMS    = 1048575
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bwss_in_if.sink                       in_chan,
  bwss_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [bwss_pkg::BUDGET_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int LW = $clog2(WINDOW_DEPTH + 1);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int VW = bwss_pkg::VALUE_W;
  localparam int SW = bwss_pkg::SUM_W;
  localparam int IW = bwss_pkg::IDX_W;

  bwss_pkg::state_t state_r, state_nxt;

  logic [bwss_pkg::BUDGET_W-1:0] budget_r;
  logic [AW-1:0]                 head_r, head_nxt;
  logic [AW-1:0]                 tail_r;
  logic [LW-1:0]                 len_r;
  logic [SW-1:0]                 sum_r;
  logic [IW-1:0]                 start_r;
  logic [CW-1:0]                 count_r;
  logic                          ovf_r;
  logic [VW-1:0]                 v_r;
  logic                          last_r;

  logic [VW-1:0]                 mem [WINDOW_DEPTH];
  logic [VW-1:0]                 rd_data_r;

  logic                          out_valid_r;
  bwss_pkg::kept_t               out_kept_r;
  logic                          out_ovf_r;

  logic                          accept, room, full, over;
  logic                          in_ready, do_push, do_drop, set_ovf, load_out, seq_clear;
  logic [VW-1:0]                 push_val;
  logic [SW-1:0]                 drop_sum;
  bwss_pkg::score_req_t          score_req;
  bwss_pkg::kept_t               kept;

  // status of the window
  assign accept = in_chan.valid && in_ready;
  assign room   = count_r < CW'(MAX_ITEMS);
  assign full   = len_r == LW'(WINDOW_DEPTH);
  assign over   = (sum_r > {1'b0, budget_r}) && (len_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bwss_pkg::ST_IDLE: begin
        if (accept) begin
          if (!room) begin
            state_nxt = in_chan.last ? bwss_pkg::ST_FINAL : bwss_pkg::ST_IDLE;
          end else if (full) begin
            state_nxt = bwss_pkg::ST_PUSH;
          end else begin
            state_nxt = bwss_pkg::ST_CHECK;
          end
        end
      end
      bwss_pkg::ST_PUSH:  state_nxt = bwss_pkg::ST_CHECK;
      bwss_pkg::ST_CHECK: begin
        if (!over) begin
          state_nxt = last_r ? bwss_pkg::ST_FINAL : bwss_pkg::ST_IDLE;
        end
      end
      bwss_pkg::ST_FINAL: state_nxt = bwss_pkg::ST_EMIT;
      bwss_pkg::ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = bwss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bwss_pkg::ST_IDLE;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    do_push   = 1'b0;
    do_drop   = 1'b0;
    set_ovf   = 1'b0;
    load_out  = 1'b0;
    seq_clear = 1'b0;
    score_req = '0;
    unique case (state_r)
      bwss_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && room) begin
          if (full) begin
            // store full: score the whole window, then drop the oldest
            set_ovf             = 1'b1;
            do_drop             = 1'b1;
            score_req.en        = 1'b1;
            score_req.sum       = sum_r;
            score_req.first_idx = start_r;
            score_req.last_idx  = IW'(count_r);
          end else begin
            do_push = 1'b1;
          end
        end
      end
      bwss_pkg::ST_PUSH: do_push = 1'b1;
      bwss_pkg::ST_CHECK: begin
        if (over) begin
          // score the window ending before the new value, then shrink
          do_drop             = 1'b1;
          score_req.en        = 1'b1;
          score_req.sum       = sum_r - SW'(v_r);
          score_req.first_idx = start_r;
          score_req.last_idx  = IW'(count_r - CW'(1));
        end
      end
      bwss_pkg::ST_FINAL: begin
        score_req.en        = 1'b1;
        score_req.sum       = sum_r;
        score_req.first_idx = start_r;
        score_req.last_idx  = IW'(count_r);
      end
      bwss_pkg::ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          seq_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign push_val = (state_r == bwss_pkg::ST_IDLE) ? in_chan.value : v_r;
  assign drop_sum = (sum_r >= SW'(rd_data_r)) ? (sum_r - SW'(rd_data_r)) : '0;
  assign head_nxt = !do_drop ? head_r :
                    (head_r == AW'(WINDOW_DEPTH - 1)) ? '0 : head_r + AW'(1);

  // ring memory; read port always fetches the oldest entry, write-first forward
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail_r] <= push_val;
    end
    if (do_push && (tail_r == head_nxt)) begin
      rd_data_r <= push_val;
    end else begin
      rd_data_r <= mem[head_nxt];
    end
  end

  // sequencer state and budget register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bwss_pkg::ST_IDLE;
      budget_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        budget_r <= cfg_wdata;
      end
    end
  end

  // window pointers, running sum and counters
  always_ff @(posedge clk) begin
    if (!rst_n || seq_clear) begin
      head_r  <= '0;
      tail_r  <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      start_r <= IW'(1);
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      head_r <= head_nxt;
      if (do_push) begin
        tail_r  <= (tail_r == AW'(WINDOW_DEPTH - 1)) ? '0 : tail_r + AW'(1);
        len_r   <= len_r + LW'(1);
        sum_r   <= sum_r + SW'(push_val);
        count_r <= count_r + CW'(1);
      end else if (do_drop) begin
        len_r   <= len_r - LW'(1);
        sum_r   <= drop_sum;
        start_r <= start_r + IW'(1);
      end
      if (set_ovf) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // item capture on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      v_r    <= in_chan.value;
      last_r <= in_chan.last;
    end
  end

  bwss_keeper u_keeper (
    .clk    (clk),
    .rst_n  (rst_n),
    .budget (budget_r),
    .req    (score_req),
    .clear  (seq_clear),
    .kept   (kept)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_kept_r <= kept;
      out_ovf_r  <= ovf_r;
    end
  end

  assign in_chan.ready            = in_ready;
  assign out_chan.valid           = out_valid_r;
  assign out_chan.best_start      = out_kept_r.first_idx;
  assign out_chan.best_end        = out_kept_r.last_idx;
  assign out_chan.best_sum        = out_kept_r.sum;
  assign out_chan.window_overflow = out_ovf_r;

  // window never holds more than the store depth
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LW'(WINDOW_DEPTH))
    else $error("window length beyond store depth");

  // shrinking stops only once the window fits the budget
  a_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bwss_pkg::ST_CHECK && state_nxt != bwss_pkg::ST_CHECK)
      |-> (sum_r <= {1'b0, budget_r} || len_r == '0))
    else $error("window left over budget");

  // a result appears only after the emit step
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bwss_pkg::ST_EMIT))
    else $error("result raised outside emit");

  // item count stays within its limit
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("item count beyond limit");

endmodule
